[rtl/drme_pkg.sv]
// Package for the DRAM row majority engine: item types, operation and status
// codes, sequencer states and default sizes. No dependencies.
package drme_pkg;

	localparam int unsigned LANES_DEF        = 64;
	localparam int unsigned ROWS_DEF         = 1024;
	localparam int unsigned MAX_OPERANDS_DEF = 5;

	localparam int unsigned ROW_FIELD_W = 10;
	localparam int unsigned DATA_W      = 64;
	localparam int unsigned FIELD_ROWS  = 1 << ROW_FIELD_W;
	localparam int unsigned NUM_FIELDS  = 5;

	localparam logic [2:0] OP_WRITE     = 3'd0;
	localparam logic [2:0] OP_READ      = 3'd1;
	localparam logic [2:0] OP_COPY      = 3'd2;
	localparam logic [2:0] OP_NOT       = 3'd3;
	localparam logic [2:0] OP_NOT_COPY  = 3'd4;
	localparam logic [2:0] OP_MAJ3      = 3'd5;
	localparam logic [2:0] OP_MAJ5      = 3'd6;
	localparam logic [2:0] OP_BROADCAST = 3'd7;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_BAD_COUNT   = 2'd2;
	localparam logic [1:0] ST_UNWRITTEN   = 2'd3;

	typedef struct packed {
		logic [2:0]             operation;
		logic [2:0]             operand_count;
		logic [ROW_FIELD_W-1:0] row_first;
		logic [ROW_FIELD_W-1:0] row_second;
		logic [ROW_FIELD_W-1:0] row_third;
		logic [ROW_FIELD_W-1:0] row_fourth;
		logic [ROW_FIELD_W-1:0] row_fifth;
		logic [DATA_W-1:0]      write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] read_data;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_REDUCE,
		S_CHECK,
		S_READ,
		S_READ_LAST,
		S_EVAL,
		S_WRITE,
		S_DONE
	} state_t;

endpackage

[rtl/drme_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module drme_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

[rtl/dram_row_majority_engine.sv]
// DRAM row majority engine: bulk bitwise row operations over one single-port row RAM.
// Depends on drme_pkg and drme_ram.
// Sequence: a bad count goes straight to the result; a write skips the row reads; row indices
// are first reduced mod ROWS by restoring steps when ROWS is below 1024.
// One item at a time; an unwritten source skips the writes; ready returns in the same cycle as
// rsp_valid, later while an earlier result stalls. Reset runs a clear that zeroes every row.
module dram_row_majority_engine
	import drme_pkg::*;
#(
	parameter int unsigned LANES        = LANES_DEF,
	parameter int unsigned ROWS         = ROWS_DEF,
	parameter int unsigned MAX_OPERANDS = MAX_OPERANDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int unsigned AW       = $clog2(ROWS);
	localparam int unsigned OPW      = $clog2(MAX_OPERANDS);
	localparam int unsigned MEM_W    = LANES + 1;
	localparam bit          NEED_MOD = (ROWS < FIELD_ROWS);
	localparam logic [ROW_FIELD_W:0] ROWS_CMP =
		NEED_MOD ? (ROW_FIELD_W+1)'(ROWS) : (ROW_FIELD_W+1)'(FIELD_ROWS);
	localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);
	localparam logic [3:0]    STEP_TOP = 4'(ROW_FIELD_W - 1);

	state_t state_q, state_d;

	req_t                   req_q;
	logic [ROW_FIELD_W-1:0] idx_q [MAX_OPERANDS];
	logic [ROW_FIELD_W-1:0] idx_red [MAX_OPERANDS];
	logic [ROW_FIELD_W-1:0] fields [NUM_FIELDS];
	logic [3:0]             step_q;
	logic [2:0]             rd_k_q;
	logic [2:0]             wr_k_q;
	logic [2:0]             wr_last_q;
	logic [2:0]             nsrc_q;
	logic                   rd_pend_q;
	logic                   unwritten_q;
	logic [2:0]             ones_q [LANES];
	logic [LANES-1:0]       res_q;
	logic [1:0]             status_q;
	logic [AW-1:0]          clr_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic                   bad_count;
	logic                   is_maj;
	logic                   rsp_free;
	logic                   mem_en;
	logic                   mem_we;
	logic [AW-1:0]          mem_addr;
	logic [MEM_W-1:0]       mem_wdata;
	logic [MEM_W-1:0]       mem_rdata;

	drme_ram #(
		.WIDTH(MEM_W),
		.DEPTH(ROWS)
	) u_row_ram (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign fields[0] = req.row_first;
	assign fields[1] = req.row_second;
	assign fields[2] = req.row_third;
	assign fields[3] = req.row_fourth;
	assign fields[4] = req.row_fifth;

	assign is_maj   = (req_q.operation == OP_MAJ3) || (req_q.operation == OP_MAJ5);
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		bad_count = 1'b0;
		if (req_q.operand_count == 3'd0 || req_q.operand_count > 3'(MAX_OPERANDS)) begin
			bad_count = 1'b1;
		end else if (req_q.operation == OP_MAJ3 && req_q.operand_count != 3'd3) begin
			bad_count = 1'b1;
		end else if (req_q.operation == OP_MAJ5 && req_q.operand_count != 3'd5) begin
			bad_count = 1'b1;
		end else if (req_q.operation == OP_COPY && req_q.operand_count < 3'd2) begin
			bad_count = 1'b1;
		end
	end

	// one restoring step of index mod ROWS for every operand
	always_comb begin
		logic [ROW_FIELD_W:0] sub;
		sub = ROWS_CMP << step_q;
		for (int k = 0; k < int'(MAX_OPERANDS); k++) begin
			if ({1'b0, idx_q[k] >> step_q} >= ROWS_CMP) begin
				idx_red[k] = idx_q[k] - sub[ROW_FIELD_W-1:0];
			end else begin
				idx_red[k] = idx_q[k];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_ROW) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = NEED_MOD ? S_REDUCE : S_CHECK;
				end
			end
			S_REDUCE: begin
				if (step_q == 4'd0) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (bad_count) begin
					state_d = S_DONE;
				end else if (req_q.operation == OP_WRITE) begin
					state_d = S_WRITE;
				end else if (is_maj) begin
					state_d = S_READ;
				end else begin
					state_d = S_READ_LAST;
				end
			end
			S_READ: begin
				if (rd_k_q == nsrc_q - 3'd2) begin
					state_d = S_READ_LAST;
				end
			end
			S_READ_LAST: state_d = S_EVAL;
			S_EVAL: begin
				if (unwritten_q || !mem_rdata[LANES] || req_q.operation == OP_READ) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (wr_k_q == wr_last_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = AW'(idx_q[rd_k_q[OPW-1:0]]);
		mem_wdata = {1'b1, res_q};
		case (state_q)
			S_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: req_ready = 1'b1;
			S_READ, S_READ_LAST: mem_en = 1'b1;
			S_WRITE: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = AW'(idx_q[wr_k_q[OPW-1:0]]);
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_pend_q <= (state_q == S_READ);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q  <= req;
				step_q <= STEP_TOP;
				for (int k = 0; k < int'(MAX_OPERANDS); k++) begin
					idx_q[k] <= fields[k];
				end
			end
			S_REDUCE: begin
				step_q <= step_q - 4'd1;
				for (int k = 0; k < int'(MAX_OPERANDS); k++) begin
					idx_q[k] <= idx_red[k];
				end
			end
			S_CHECK: begin
				rd_k_q      <= '0;
				unwritten_q <= 1'b0;
				nsrc_q      <= is_maj ? req_q.operand_count : 3'd1;
				status_q    <= bad_count ? ST_BAD_COUNT : ST_OK;
				wr_k_q      <= (req_q.operation == OP_COPY) ? 3'd1 : 3'd0;
				wr_last_q   <= (req_q.operation == OP_WRITE) ? 3'd0
					: req_q.operand_count - 3'd1;
				for (int l = 0; l < int'(LANES); l++) begin
					ones_q[l] <= '0;
				end
			end
			S_READ, S_READ_LAST: begin
				rd_k_q <= rd_k_q + 3'd1;
				// accumulate the row issued last cycle
				if (rd_pend_q) begin
					unwritten_q <= unwritten_q | ~mem_rdata[LANES];
					for (int l = 0; l < int'(LANES); l++) begin
						ones_q[l] <= ones_q[l] + 3'(mem_rdata[l]);
					end
				end
			end
			S_EVAL: begin
				unwritten_q <= unwritten_q | ~mem_rdata[LANES];
				for (int l = 0; l < int'(LANES); l++) begin
					ones_q[l] <= ones_q[l] + 3'(mem_rdata[l]);
				end
			end
			S_WRITE: wr_k_q <= wr_k_q + 3'd1;
			default: begin
			end
		endcase
		// the last row lands in EVAL; fold it in before choosing the result
		if (state_q == S_EVAL) begin
			if (unwritten_q || !mem_rdata[LANES]) begin
				status_q <= ST_UNWRITTEN;
			end
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.status    <= status_q;
			rsp_q.read_data <= (status_q == ST_OK && req_q.operation == OP_READ)
				? DATA_W'(res_q) : '0;
		end
	end

	// result row from the counts once the final row is included
	logic [LANES-1:0] maj_fin;
	always_comb begin
		for (int l = 0; l < int'(LANES); l++) begin
			maj_fin[l] = ((ones_q[l] + 3'(mem_rdata[l])) > (nsrc_q >> 1));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			if (req_q.operation == OP_NOT || req_q.operation == OP_NOT_COPY) begin
				res_q <= ~maj_fin;
			end else begin
				res_q <= maj_fin;
			end
		end else if (state_q == S_CHECK) begin
			res_q <= LANES'(req_q.write_data);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/drme_checker.sv]
// Port-level checker for the DRAM row majority engine, bound to the top level.
// Depends on drme_pkg.
module drme_checker
	import drme_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// an accepted item keeps the engine busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("engine ready right after taking an item");

	// every operation code is supported
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != ST_UNSUPPORTED)
		else $error("unsupported status reported");

	// read data is zero on a failed item
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_data == '0)
		else $error("nonzero read data on a failed item");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

endmodule

bind dram_row_majority_engine drme_checker u_drme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
